/* hdl/vzbc_pkg.sv */
// Shared types and constants for the varint zigzag buffer codec.
`default_nettype none

package vzbc_pkg;

   localparam int VALUE_W           = 64;
   localparam int COUNT_W           = 9;
   localparam int GROUP_W           = 7;
   localparam int GROUP_CNT         = 10;
   localparam int GCNT_W            = 4;
   localparam int BYTE_W            = 8;
   localparam int BUF_BYTES_DEFAULT = 256;

   typedef enum logic [1:0] {
      KIND_ENCODE  = 2'd0,
      KIND_DECODE  = 2'd1,
      KIND_REWIND  = 2'd2,
      KIND_MEASURE = 2'd3
   } kind_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   function automatic logic [VALUE_W-1:0] zz_map(input logic [VALUE_W-1:0] v);
      return {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
   endfunction

   function automatic logic [VALUE_W-1:0] zz_unmap(input logic [VALUE_W-1:0] r);
      return {1'b0, r[VALUE_W-1:1]} ^ {VALUE_W{r[0]}};
   endfunction

endpackage

`default_nettype wire

/* hdl/varint_zigzag_buffer_codec_unit.sv */
// Top level of the LEB128 varint codec with zigzag mapping over a byte buffer.
//
//   channel | direction | ports                                         | transfer
//   req     | in        | req_kind, req_zigzag, req_value               | req_valid & req_ready
//   rsp     | out       | rsp_status, rsp_count, rsp_decoded, rsp_bytes_used | rsp_valid & rsp_ready
//
// One request is worked at a time. Encode and measure handle one 7-bit group per cycle
// through a shift register; an encoded varint is at most 10 bytes. Decode reads each
// byte through the buffer RAM's registered port, in an address state and a data state.
// Rewind clears the read cursor. Reset clears both cursors; the buffer needs no
// clearing pass. A pending response does not block the next request; a finished
// request waits only when the response register is still full.
`default_nettype none

module varint_zigzag_buffer_codec_unit #(
   parameter int BUF_BYTES = vzbc_pkg::BUF_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic                           req_zigzag,
   input  wire logic [vzbc_pkg::VALUE_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_status,
   output logic      [vzbc_pkg::COUNT_W-1:0]   rsp_count,
   output logic      [vzbc_pkg::VALUE_W-1:0]   rsp_decoded,
   output logic      [vzbc_pkg::COUNT_W-1:0]   rsp_bytes_used
);

   import vzbc_pkg::*;

   localparam int PTR_W  = $clog2(BUF_BYTES + 1);
   localparam int ADDR_W = $clog2(BUF_BYTES);
   localparam int ACC_W  = GROUP_CNT * GROUP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENC,
      ST_MEAS,
      ST_DEC_ADDR,
      ST_DEC_DATA,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_W-1:0]      val_ff, val_in;
   logic                    zz_ff, zz_in;
   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic [PTR_W-1:0]        rp_ff, rp_in;
   logic [PTR_W-1:0]        cnt_ff, cnt_in;
   status_type              status_ff, status_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [GCNT_W-1:0]       gcnt_ff, gcnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]      rsp_decoded_ff, rsp_decoded_in;
   logic [COUNT_W-1:0]      rsp_bytes_used_ff, rsp_bytes_used_in;

   logic                    more;
   logic                    ram_wr_en;
   logic [BYTE_W-1:0]       ram_wr_data;
   logic [BYTE_W-1:0]       ram_rd_data;
   logic [VALUE_W-1:0]      acc_value;

   vzbc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUF_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff[ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (rp_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Another group follows whenever anything is left above the low seven bits.
   assign more        = |val_ff[VALUE_W-1:GROUP_W];
   assign ram_wr_data = {more, val_ff[GROUP_W-1:0]};
   assign acc_value   = acc_ff[VALUE_W-1:0];
   assign req_ready   = (state_ff == ST_IDLE);

   always_comb begin
      state_in          = state_ff;
      val_in            = val_ff;
      zz_in             = zz_ff;
      wp_in             = wp_ff;
      rp_in             = rp_ff;
      cnt_in            = cnt_ff;
      status_in         = status_ff;
      acc_in            = acc_ff;
      gcnt_in           = gcnt_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_decoded_in    = rsp_decoded_ff;
      rsp_bytes_used_in = rsp_bytes_used_ff;
      ram_wr_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in    = req_zigzag ? zz_map(req_value) : req_value;
               zz_in     = req_zigzag;
               cnt_in    = '0;
               status_in = STATUS_OK;
               acc_in    = '0;
               gcnt_in   = '0;
               case (kind_type'(req_kind))
                  KIND_ENCODE:  state_in = ST_ENC;
                  KIND_DECODE:  state_in = ST_DEC_ADDR;
                  KIND_REWIND: begin
                     rp_in    = '0;
                     state_in = ST_DONE;
                  end
                  KIND_MEASURE: state_in = ST_MEAS;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_ENC: begin
            if (wp_ff >= PTR_W'(BUF_BYTES)) begin
               status_in = STATUS_FULL;
               state_in  = ST_DONE;
            end else begin
               ram_wr_en = 1'b1;
               wp_in     = wp_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               val_in    = val_ff >> GROUP_W;
               if (!more) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MEAS: begin
            cnt_in = cnt_ff + 1'b1;
            val_in = val_ff >> GROUP_W;
            if (!more) begin
               state_in = ST_DONE;
            end
         end
         ST_DEC_ADDR: begin
            if (rp_ff < wp_ff) begin
               state_in = ST_DEC_DATA;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DEC_DATA: begin
            rp_in  = rp_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            // Groups past the tenth lie wholly above bit 63 and are dropped.
            if (gcnt_ff < GCNT_W'(GROUP_CNT)) begin
               for (int i = 0; i < GROUP_CNT; i++) begin
                  if (gcnt_ff == GCNT_W'(i)) begin
                     acc_in[i*GROUP_W +: GROUP_W] = ram_rd_data[GROUP_W-1:0];
                  end
               end
               gcnt_in = gcnt_ff + 1'b1;
            end
            if (ram_rd_data[BYTE_W-1]) begin
               state_in = ST_DEC_ADDR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_count_in      = COUNT_W'(cnt_ff);
               rsp_decoded_in    = zz_ff ? zz_unmap(acc_value) : acc_value;
               rsp_bytes_used_in = COUNT_W'(wp_ff);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         gcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         gcnt_ff      <= gcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff            <= val_in;
      zz_ff             <= zz_in;
      cnt_ff            <= cnt_in;
      status_ff         <= status_in;
      acc_ff            <= acc_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_decoded_ff    <= rsp_decoded_in;
      rsp_bytes_used_ff <= rsp_bytes_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_decoded    = rsp_decoded_ff;
   assign rsp_bytes_used = rsp_bytes_used_ff;

`ifndef ASSERT_OFF
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_W'(BUF_BYTES))
      else $error("write position beyond buffer");

   a_rp_le_wp: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= wp_ff)
      else $error("read cursor passed write position");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (wp_ff < PTR_W'(BUF_BYTES)))
      else $error("buffer write with no room left");

   a_gcnt_bound: assert property (@(posedge clock) disable iff (reset)
      gcnt_ff <= GCNT_W'(GROUP_CNT))
      else $error("group counter overran");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside completion state");
`endif

endmodule

`default_nettype wire

/* hdl/vzbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vzbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
